[rtl/core/lpcr_pkg.sv]
// Package for the LPC residual FIR: payload structs, coefficient and config types,
// and the saturating fixed-point helpers used by the datapath.
// No dependencies.
`default_nettype none

package lpcr_pkg;

	// Filter order and derived tap counts
	localparam int ORDER     = 10;
	localparam int NTAPS     = ORDER + 1;
	localparam int SPLIT     = NTAPS / 2;
	localparam int TAIL      = NTAPS - SPLIT;
	localparam int NUM_PAIRS = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 3'd5;

	// Reset value of coefficient pair 0 (a0 = 1.0 in Q12)
	localparam logic [CFG_DAT_W-1:0] PAIR0_RESET = 32'd4096;

	// Output scaling
	localparam int FINAL_SHIFT = 3;
	localparam int OUT_SHIFT   = 16;

	typedef logic signed [15:0] smp_t;
	typedef logic signed [31:0] acc_t;
	typedef logic [15:0]        coef_t;
	typedef coef_t [NTAPS-1:0]  coef_vec_t;

	localparam acc_t ACC_MAX   = 32'sh7FFF_FFFF;
	localparam acc_t ACC_MIN   = 32'sh8000_0000;
	localparam acc_t ROUND_ADD = 32'sd4096;
	localparam smp_t SMP_MIN   = 16'sh8000;

	typedef struct packed {
		smp_t sample;
		logic frame_end;
	} in_item_t;

	typedef struct packed {
		smp_t residual;
		logic frame_end_out;
	} out_item_t;

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
	} cfg_wr_t;

	// Fractional multiply: product doubled, clamped to 32 bits
	function automatic acc_t frac_mult(input smp_t a, input smp_t b);
		acc_t p;
		p = 32'(a) * 32'(b);
		if ((a == SMP_MIN) && (b == SMP_MIN)) return ACC_MAX;
		return p <<< 1;
	endfunction

	// Saturating 32-bit add
	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) return s[32] ? ACC_MIN : ACC_MAX;
		return s[31:0];
	endfunction

	// Add rounding constant, then saturating left shift
	function automatic acc_t round_shift(input acc_t a);
		acc_t r;
		r = sat_add(a, ROUND_ADD);
		if (r[31 -: FINAL_SHIFT+1] == {(FINAL_SHIFT+1){r[31]}}) return r <<< FINAL_SHIFT;
		return r[31] ? ACC_MIN : ACC_MAX;
	endfunction

endpackage

`default_nettype wire

[rtl/core/lpcr_cfg.sv]
// Coefficient register file of the LPC residual FIR.
// Depends on lpcr_pkg; presents all taps as one coefficient vector.
`default_nettype none

module lpcr_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpcr_pkg::cfg_wr_t   wr,
	output lpcr_pkg::coef_vec_t      coef
);
	import lpcr_pkg::*;

	logic [CFG_DAT_W-1:0] pair_q [NUM_PAIRS];
	coef_t                last_q;

	// Store register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q[0] <= PAIR0_RESET;
			for (int i = 1; i < NUM_PAIRS; i++) pair_q[i] <= '0;
			last_q    <= '0;
		end else if (wr.en) begin
			case (wr.idx) inside
				[REG_COEF_PAIR_0:REG_COEF_PAIR_4]: pair_q[wr.idx] <= wr.data;
				REG_COEF_LAST: last_q <= wr.data[15:0];
				default: ;
			endcase
		end
	end

	// Unpack coefficients in tap order; taps past a10 read as zero
	for (genvar k = 0; k < NTAPS; k++) begin : g_coef
		if (k < 2 * NUM_PAIRS) begin : g_pair
			assign coef[k] = pair_q[k / 2][(k % 2) * 16 +: 16];
		end else if (k == 2 * NUM_PAIRS) begin : g_last
			assign coef[k] = last_q;
		end else begin : g_zero
			assign coef[k] = '0;
		end
	end

`ifndef SYNTHESIS
	default disable iff (!arst_n);

	a_pair_write: assert property (@(posedge clk)
		wr.en && (wr.idx == REG_COEF_PAIR_0) |=> pair_q[0] == $past(wr.data))
		else $error("coefficient pair 0 not updated by write");

	a_last_write: assert property (@(posedge clk)
		wr.en && (wr.idx == REG_COEF_LAST) |=> last_q == $past(wr.data[15:0]))
		else $error("last coefficient not updated by write");

	a_hold: assert property (@(posedge clk)
		!wr.en |=> $stable(last_q) && $stable(pair_q[0]) && $stable(pair_q[4]))
		else $error("coefficients changed without a write");
`endif

endmodule

`default_nettype wire

[rtl/core/lpc_residual_fir_unit.sv]
// Top level of the order-10 LPC residual FIR: delay line and a four-stage datapath
// ending in the output register. Depends on lpcr_pkg and lpcr_cfg.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample_item) carries one speech
//   sample and a frame_end flag per transaction. result channel (result_valid /
//   result_stall / result_item) returns one residual per sample, in order, with
//   frame_end copied to frame_end_out. The delay line runs on across frame ends.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the Q12
//   coefficient registers; cfg_ready is always high. Write only while idle.
// Throughput: one sample per cycle until a stalled result fills every stage.
//   The stages are input capture, eleven parallel 16x16 multiplies, then the
//   saturating accumulate chain in tap order split over two stages (rounding
//   and the final shift in the last).
// Reset: pipeline empty, delay line zero, a0 = 4096 and all other taps zero.
// Stall: a stalled result holds; upstream stages keep filling until every
//   stage is full, and only then sample_stall rises.
`default_nettype none

module lpc_residual_fir_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	output logic                                       sample_stall,
	input  wire lpcr_pkg::in_item_t                    sample_item,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output lpcr_pkg::out_item_t                        result_item,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lpcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [lpcr_pkg::CFG_DAT_W-1:0]        cfg_data
);
	import lpcr_pkg::*;

	cfg_wr_t   cfg_wr;
	coef_vec_t coef;

	smp_t hist_q [ORDER];

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic accept;

	smp_t taps_s1 [NTAPS];
	logic fe_s1;
	acc_t prod_s2 [NTAPS];
	logic fe_s2;
	acc_t acc_s3;
	acc_t tail_s3 [TAIL];
	logic fe_s3;
	out_item_t res_s4;

	acc_t head_sum;
	acc_t tail_sum;
	acc_t final_acc;

	// Configuration port
	assign cfg_ready     = 1'b1;
	assign cfg_wr.en     = cfg_valid;
	assign cfg_wr.idx    = cfg_index;
	assign cfg_wr.data   = cfg_data;

	lpcr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_wr),
		.coef   (coef)
	);

	// Per-stage ready: a stage loads when empty or when its successor loads
	assign rdy_s4       = !v_s4 || !result_stall;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign accept       = sample_valid && rdy_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= sample_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Delay line: shift on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) hist_q[i] <= '0;
		end else if (accept) begin
			for (int i = ORDER - 1; i > 0; i--) hist_q[i] <= hist_q[i - 1];
			hist_q[0] <= sample_item.sample;
		end
	end

	// Stage 1: capture the sample with a snapshot of the delay line
	always_ff @(posedge clk) begin
		if (accept) begin
			taps_s1[0] <= sample_item.sample;
			for (int i = 1; i < NTAPS; i++) taps_s1[i] <= hist_q[i - 1];
			fe_s1 <= sample_item.frame_end;
		end
	end

	// Stage 2: all tap products in parallel
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int i = 0; i < NTAPS; i++) prod_s2[i] <= frac_mult(smp_t'(coef[i]), taps_s1[i]);
			fe_s2 <= fe_s1;
		end
	end

	// Accumulate the leading taps in order
	always_comb begin
		head_sum = prod_s2[0];
		for (int i = 1; i < SPLIT; i++) head_sum = sat_add(head_sum, prod_s2[i]);
	end

	// Stage 3: partial sum plus the remaining products
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			acc_s3 <= head_sum;
			for (int i = 0; i < TAIL; i++) tail_s3[i] <= prod_s2[SPLIT + i];
			fe_s3 <= fe_s2;
		end
	end

	// Finish the chain, round and scale
	always_comb begin
		tail_sum = acc_s3;
		for (int i = 0; i < TAIL; i++) tail_sum = sat_add(tail_sum, tail_s3[i]);
		final_acc = round_shift(tail_sum);
	end

	// Stage 4: result register
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			res_s4.residual      <= final_acc[OUT_SHIFT +: 16];
			res_s4.frame_end_out <= fe_s3;
		end
	end

	assign result_valid = v_s4;
	assign result_item  = res_s4;

`ifndef SYNTHESIS
	default disable iff (!arst_n);

	a_accept_fills: assert property (@(posedge clk)
		accept |=> v_s1)
		else $error("accepted transaction did not reach stage 1");

	a_hist_newest: assert property (@(posedge clk)
		accept |=> hist_q[0] == $past(sample_item.sample))
		else $error("delay line head does not hold the accepted sample");

	a_full_stall: assert property (@(posedge clk)
		v_s1 && v_s2 && v_s3 && v_s4 && result_stall |-> sample_stall)
		else $error("sample taken while pipeline full and output stalled");

	a_bubble_take: assert property (@(posedge clk)
		!v_s1 |-> !sample_stall)
		else $error("sample stalled while stage 1 empty");
`endif

endmodule

`default_nettype wire
